/* hw/rtl/tg_pkg.sv */
// Shared types and constants for the touch gesture classifier.
// Holds the sample and event payload structs, the mode and event codes
// and the register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tg_pkg;

  localparam int CoordBits = 10;
  localparam int CountBits = 4;
  localparam int KindBits  = 3;
  localparam int SwipeMin  = 10;
  localparam int LenientTol = 3;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    logic [CountBits-1:0] point_count;
    coord_t               touch_x;
    coord_t               touch_y;
    logic                 invalidate;
  } tg_in_t;

  typedef struct packed {
    logic [KindBits-1:0] event_kind;
    coord_t              event_x;
    coord_t              event_y;
  } tg_out_t;

  typedef struct packed {
    logic hw_ok;
    logic lenient_click;
  } tg_cfg_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_ACTIVE  = 3'b010,
    MODE_INVALID = 3'b100
  } mode_t;

  typedef enum logic [KindBits-1:0] {
    EV_CLICK       = 3'd0,
    EV_SWIPE_UP    = 3'd1,
    EV_SWIPE_DOWN  = 3'd2,
    EV_SWIPE_LEFT  = 3'd3,
    EV_SWIPE_RIGHT = 3'd4
  } event_kind_t;

  typedef enum logic {
    REG_HW_OK         = 1'b0,
    REG_LENIENT_CLICK = 1'b1
  } reg_index_t;

endpackage

`default_nettype wire

/* hw/rtl/tg_classify.sv */
// Gesture classification from the start and last positions.
// Pure combinational; depends on tg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tg_classify (
  input  tg_pkg::coord_t      start_x,
  input  tg_pkg::coord_t      start_y,
  input  tg_pkg::coord_t      last_x,
  input  tg_pkg::coord_t      last_y,
  input  logic                lenient_click,
  output logic                hit,
  output tg_pkg::event_kind_t kind
);
  import tg_pkg::*;

  coord_t               ax;
  coord_t               ay;
  logic [CoordBits:0]   ax2;
  logic [CoordBits:0]   ay2;
  coord_t               tol;
  logic                 is_click;
  logic                 is_vert;
  logic                 is_horz;

  assign ax  = (last_x >= start_x) ? last_x - start_x : start_x - last_x;
  assign ay  = (last_y >= start_y) ? last_y - start_y : start_y - last_y;
  assign ax2 = {ax, 1'b0};
  assign ay2 = {ay, 1'b0};
  assign tol = lenient_click ? CoordBits'(LenientTol) : '0;

  assign is_click = (ax <= tol) && (ay <= tol);
  assign is_vert  = (ay >= CoordBits'(SwipeMin)) && (ax2 <= {1'b0, ay});
  assign is_horz  = (ax >= CoordBits'(SwipeMin)) && (ay2 <= {1'b0, ax});

  always_comb begin
    hit  = 1'b1;
    kind = EV_CLICK;
    if (is_click) begin
      kind = EV_CLICK;
    end else if (is_vert) begin
      kind = (last_y < start_y) ? EV_SWIPE_UP : EV_SWIPE_DOWN;
    end else if (is_horz) begin
      kind = (last_x < start_x) ? EV_SWIPE_LEFT : EV_SWIPE_RIGHT;
    end else begin
      hit = 1'b0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tg_track.sv */
// Gesture state tracking: mode, start and previous positions.
// Steps once per processed sample while hw_ok is set; depends on tg_pkg and tg_classify.
`timescale 1ns / 1ps
`default_nettype none

module tg_track (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  tg_pkg::tg_in_t  sample,
  input  tg_pkg::tg_cfg_t cfg,
  output logic            res_valid,
  output tg_pkg::tg_out_t res
);
  import tg_pkg::*;

  mode_t       mode;
  mode_t       mode_next;
  coord_t      start_x;
  coord_t      start_y;
  coord_t      prev_x;
  coord_t      prev_y;
  logic        hit;
  event_kind_t kind;
  logic        step;

  tg_classify u_classify (
    .start_x       (start_x),
    .start_y       (start_y),
    .last_x        (prev_x),
    .last_y        (prev_y),
    .lenient_click (cfg.lenient_click),
    .hit           (hit),
    .kind          (kind)
  );

  assign step = fire && cfg.hw_ok;

  always_comb begin
    mode_next = mode;
    res_valid = 1'b0;
    if (sample.invalidate) begin
      mode_next = MODE_INVALID;
    end else if (sample.point_count == CountBits'(1) && mode == MODE_IDLE) begin
      mode_next = MODE_ACTIVE;
    end else if (sample.point_count > CountBits'(1)) begin
      mode_next = MODE_INVALID;
    end else if (sample.point_count == '0 && mode != MODE_IDLE) begin
      // Only an active gesture yields an event; an invalid one just ends.
      res_valid = (mode == MODE_ACTIVE) && hit && step;
      mode_next = MODE_IDLE;
    end
  end

  assign res.event_kind = kind;
  assign res.event_x    = start_x;
  assign res.event_y    = start_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      start_x <= '0;
      start_y <= '0;
      prev_x  <= '0;
      prev_y  <= '0;
    end else if (step) begin
      mode   <= mode_next;
      prev_x <= sample.touch_x;
      prev_y <= sample.touch_y;
      if (mode == MODE_IDLE && mode_next == MODE_ACTIVE) begin
        start_x <= sample.touch_x;
        start_y <= sample.touch_y;
      end
    end
  end

  a_res_only_active: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (mode == MODE_ACTIVE && step))
    else $error("event raised outside an active gesture");

  a_inval_sticks: assert property (@(posedge clk) disable iff (rst)
    (step && sample.invalidate) |=> (mode == MODE_INVALID))
    else $error("invalidate did not mark the gesture invalid");

  a_hold_when_off: assert property (@(posedge clk) disable iff (rst)
    (fire && !cfg.hw_ok) |=> (mode == $past(mode)))
    else $error("mode changed while samples are ignored");

endmodule

`default_nettype wire

/* hw/rtl/touch_gesture_classifier.sv */
// Top level of the touch gesture classifier: sample register, config
// registers and event output register. Depends on tg_pkg and tg_track.
//
//   channel | signals                          | direction | payload
//   in      | in_valid, in_stall, in_data      | sink      | tg_in_t sample
//   out     | out_valid, out_stall, out_data   | source    | tg_out_t event
//   cfg     | cfg_valid, cfg_ready, cfg_index, | sink      | hw_ok, lenient_click
//           | cfg_data                         |           |
//
// One sample per cycle sustained while no pending event is stalled; each
// sample is held in the input register and classified into the output
// register, with state update and classification combinational between.
// Reset (synchronous) empties both registers, sets hw_ok, clears
// lenient_click and returns the mode to idle. A pending event held by
// out_stall stops processing, and in_stall then rises only once the input register is also occupied.
`timescale 1ns / 1ps
`default_nettype none

module touch_gesture_classifier (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  tg_pkg::tg_in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output tg_pkg::tg_out_t out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic            cfg_data
);
  import tg_pkg::*;

  tg_in_t  sample;
  logic    sample_valid;
  logic    fire;
  logic    accept;
  tg_cfg_t cfg;
  logic    res_valid;
  tg_out_t res;

  // The held sample moves on when the output register is free or emptying.
  assign fire      = sample_valid && (!out_valid || !out_stall);
  assign in_stall  = sample_valid && !fire;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      sample_valid <= accept || (sample_valid && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hw_ok         <= 1'b1;
      cfg.lenient_click <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_HW_OK:         cfg.hw_ok         <= cfg_data;
        REG_LENIENT_CLICK: cfg.lenient_click <= cfg_data;
        default: ;
      endcase
    end
  end

  tg_track u_track (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .sample    (sample),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_data <= res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !fire)
    else $error("pending event overwritten while stalled");

  a_sample_held: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !fire) |=> (sample_valid && $stable(sample)))
    else $error("unprocessed sample lost");

  a_stall_needs_sample: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (sample_valid && out_valid && out_stall))
    else $error("input stalled without cause");

endmodule

`default_nettype wire
